@@ src/pistok_pkg.sv @@
// package for the punctuation / identifier / string tokenizer
// holds scan mode codes, token kind codes, character constants and the shared result types
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pistok_pkg;

    // scan mode codes
    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_ID   = 2'd1;
    localparam logic [1:0] MODE_STR  = 2'd2;

    // token kind codes
    localparam logic [3:0] KIND_EQUALS  = 4'd0;
    localparam logic [3:0] KIND_LPAREN  = 4'd1;
    localparam logic [3:0] KIND_RPAREN  = 4'd2;
    localparam logic [3:0] KIND_SEMI    = 4'd3;
    localparam logic [3:0] KIND_COMMA   = 4'd4;
    localparam logic [3:0] KIND_UNKNOWN = 4'd5;
    localparam logic [3:0] KIND_ID      = 4'd6;
    localparam logic [3:0] KIND_STRING  = 4'd7;
    localparam logic [3:0] KIND_EOF     = 4'd8;

    // source characters with a meaning of their own
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_EQUALS  = 8'h3D;

    // result queue geometry
    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_PTR_W = 2;
    localparam int unsigned Q_CNT_W = 3;
    // highest fill count at which a byte is decoded (a byte makes at most two results)
    localparam logic [Q_CNT_W-1:0] Q_ROOM_LIMIT = Q_CNT_W'(Q_DEPTH - 2);

    // one result item
    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] char_out;
        logic       has_char;
        logic       token_start;
        logic       token_end;
        logic       last_of_run;
    } t_result;

    // results made by one byte, in order
    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_push;

    // full decode outcome for one byte
    typedef struct packed {
        t_push      push;
        logic [1:0] next_mode;
    } t_decode;

endpackage

`default_nettype wire

@@ src/punctuation_id_string_tokenizer.sv @@
// Tokenizer for a byte stream of identifiers, quoted strings and punctuation.
//
// Input channel: i_valid / o_stall with i_byte_in, one source byte per request.
// A zero byte ends the source: any open token is closed, an end-of-file
// result follows, and the next bytes start a fresh source.
// Output channel: o_valid / i_stall with one result per request (kind, char,
// has_char, token start / end marks, last_of_run on the last result of a byte).
// Each byte gives zero, one or two results.
//
// An accepted byte is held in the input register, decoded and written into the
// result queue, whose head drives the outputs. Throughput: one byte per cycle
// while each byte gives at most one result and the receiver does not stall; a
// two-result byte slows the input, as a single output port drains the 4-entry queue.
// The input register holds a byte until the queue has room for two results;
// while the receiver stalls, the head result holds and the queue fills, then
// o_stall rises.
// Reset (synchronous, active low) empties the input register and the queue and
// returns the scan mode to idle.
// depends on pistok_pkg, pistok_decode, pistok_outq
`timescale 1ns / 1ps
`default_nettype none

module punctuation_id_string_tokenizer (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output      logic       o_stall,
    input  wire logic [7:0] i_byte_in,
    output      logic       o_valid,
    input  wire logic       i_stall,
    output      logic [3:0] o_kind,
    output      logic [7:0] o_char_out,
    output      logic       o_has_char,
    output      logic       o_token_start,
    output      logic       o_token_end,
    output      logic       o_last_of_run
);

    logic                r_in_valid;
    logic [7:0]          r_in_byte;
    logic [1:0]          r_mode;
    logic                n_in_valid;
    logic                q_room;
    logic                consume;
    logic                accept;
    pistok_pkg::t_decode dec;
    pistok_pkg::t_result head;

    // input register hand-off
    assign consume    = r_in_valid && q_room;
    assign o_stall    = r_in_valid && !q_room;
    assign accept     = i_valid && !o_stall;
    assign n_in_valid = accept || (r_in_valid && !consume);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_byte_in;
        end
    end

    // scan mode advances when a byte is decoded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= pistok_pkg::MODE_IDLE;
        end else if (consume) begin
            r_mode <= dec.next_mode;
        end
    end

    // byte decoder
    pistok_decode u_decode (
        .i_byte (r_in_byte),
        .i_mode (r_mode),
        .o_dec  (dec)
    );

    // result queue
    pistok_outq u_outq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push_en (consume),
        .i_push    (dec.push),
        .i_pop     (!i_stall),
        .o_room    (q_room),
        .o_valid   (o_valid),
        .o_head    (head)
    );

    // result fields
    assign o_kind        = head.kind;
    assign o_char_out    = head.char_out;
    assign o_has_char    = head.has_char;
    assign o_token_start = head.token_start;
    assign o_token_end   = head.token_end;
    assign o_last_of_run = head.last_of_run;

    // checks
    a_mode_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode != 2'd3)
        else $error("unused scan mode reached");

    a_two_from_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (consume && dec.push.count == 2'd2) |-> (r_mode != pistok_pkg::MODE_IDLE))
        else $error("two results from idle mode");

    a_nul_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (consume && r_in_byte == pistok_pkg::CH_NUL) |=> (r_mode == pistok_pkg::MODE_IDLE))
        else $error("end of source left a token open");

endmodule

`default_nettype wire

@@ src/pistok_decode.sv @@
// per-byte decoder of the tokenizer: maps the current scan mode and one source byte
// to up to two result items and the next scan mode; purely combinational
// depends on pistok_pkg
`timescale 1ns / 1ps
`default_nettype none

module pistok_decode (
    input  wire logic [7:0]          i_byte,
    input  wire logic [1:0]          i_mode,
    output pistok_pkg::t_decode      o_dec
);

    function automatic pistok_pkg::t_result mk_res(
        input logic [3:0] kind,
        input logic [7:0] ch,
        input logic       has,
        input logic       start,
        input logic       stop
    );
        pistok_pkg::t_result r;
        r.kind        = kind;
        r.char_out    = has ? ch : 8'd0;
        r.has_char    = has;
        r.token_start = start;
        r.token_end   = stop;
        r.last_of_run = 1'b0;
        return r;
    endfunction

    logic                alnum;
    logic                idle_hit;
    logic [1:0]          idle_mode;
    pistok_pkg::t_result idle_res;
    pistok_pkg::t_decode dec;

    // ascii letters and digits
    assign alnum = (i_byte >= 8'h30 && i_byte <= 8'h39) ||
                   (i_byte >= 8'h41 && i_byte <= 8'h5A) ||
                   (i_byte >= 8'h61 && i_byte <= 8'h7A);

    // byte handled from idle mode
    always_comb begin
        idle_hit  = 1'b1;
        idle_mode = pistok_pkg::MODE_IDLE;
        idle_res  = '0;
        if (i_byte == pistok_pkg::CH_NUL) begin
            idle_res = mk_res(pistok_pkg::KIND_EOF, 8'd0, 1'b0, 1'b1, 1'b1);
        end else if (i_byte == pistok_pkg::CH_SPACE || i_byte == pistok_pkg::CH_NEWLINE) begin
            idle_hit = 1'b0;
        end else if (i_byte == pistok_pkg::CH_QUOTE) begin
            idle_res  = mk_res(pistok_pkg::KIND_STRING, 8'd0, 1'b0, 1'b1, 1'b0);
            idle_mode = pistok_pkg::MODE_STR;
        end else if (alnum) begin
            idle_res  = mk_res(pistok_pkg::KIND_ID, i_byte, 1'b1, 1'b1, 1'b0);
            idle_mode = pistok_pkg::MODE_ID;
        end else begin
            case (i_byte)
                pistok_pkg::CH_EQUALS: begin
                    idle_res = mk_res(pistok_pkg::KIND_EQUALS, i_byte, 1'b1, 1'b1, 1'b1);
                end
                pistok_pkg::CH_LPAREN: begin
                    idle_res = mk_res(pistok_pkg::KIND_LPAREN, i_byte, 1'b1, 1'b1, 1'b1);
                end
                pistok_pkg::CH_RPAREN: begin
                    idle_res = mk_res(pistok_pkg::KIND_RPAREN, i_byte, 1'b1, 1'b1, 1'b1);
                end
                pistok_pkg::CH_SEMI: begin
                    idle_res = mk_res(pistok_pkg::KIND_SEMI, i_byte, 1'b1, 1'b1, 1'b1);
                end
                pistok_pkg::CH_COMMA: begin
                    idle_res = mk_res(pistok_pkg::KIND_COMMA, i_byte, 1'b1, 1'b1, 1'b1);
                end
                default: begin
                    idle_res = mk_res(pistok_pkg::KIND_UNKNOWN, i_byte, 1'b1, 1'b1, 1'b1);
                end
            endcase
        end
    end

    // mode-dependent result selection
    always_comb begin
        dec = '0;
        case (i_mode)
            pistok_pkg::MODE_STR: begin
                if (i_byte == pistok_pkg::CH_QUOTE) begin
                    dec.push.res0  = mk_res(pistok_pkg::KIND_STRING, 8'd0, 1'b0, 1'b0, 1'b1);
                    dec.push.count = 2'd1;
                    dec.next_mode  = pistok_pkg::MODE_IDLE;
                end else if (i_byte == pistok_pkg::CH_NUL) begin
                    // unterminated string: close it, then end of file
                    dec.push.res0  = mk_res(pistok_pkg::KIND_STRING, 8'd0, 1'b0, 1'b0, 1'b1);
                    dec.push.res1  = idle_res;
                    dec.push.count = 2'd2;
                    dec.next_mode  = pistok_pkg::MODE_IDLE;
                end else begin
                    dec.push.res0  = mk_res(pistok_pkg::KIND_STRING, i_byte, 1'b1, 1'b0, 1'b0);
                    dec.push.count = 2'd1;
                    dec.next_mode  = pistok_pkg::MODE_STR;
                end
            end
            pistok_pkg::MODE_ID: begin
                if (alnum) begin
                    dec.push.res0  = mk_res(pistok_pkg::KIND_ID, i_byte, 1'b1, 1'b0, 1'b0);
                    dec.push.count = 2'd1;
                    dec.next_mode  = pistok_pkg::MODE_ID;
                end else begin
                    // close the identifier, then treat the byte as from idle
                    dec.push.res0  = mk_res(pistok_pkg::KIND_ID, 8'd0, 1'b0, 1'b0, 1'b1);
                    dec.push.res1  = idle_res;
                    dec.push.count = idle_hit ? 2'd2 : 2'd1;
                    dec.next_mode  = idle_mode;
                end
            end
            default: begin
                dec.push.res0  = idle_res;
                dec.push.count = idle_hit ? 2'd1 : 2'd0;
                dec.next_mode  = idle_mode;
            end
        endcase

        // mark the last result of this byte
        if (dec.push.count == 2'd1) begin
            dec.push.res0.last_of_run = 1'b1;
        end
        if (dec.push.count == 2'd2) begin
            dec.push.res1.last_of_run = 1'b1;
        end
    end

    assign o_dec = dec;

endmodule

`default_nettype wire

@@ src/pistok_outq.sv @@
// result queue of the tokenizer: takes up to two results per cycle, hands out one
// per cycle on the output channel, holds the head stable while stalled
// depends on pistok_pkg
`timescale 1ns / 1ps
`default_nettype none

module pistok_outq (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push_en,
    input  wire pistok_pkg::t_push    i_push,
    input  wire logic                 i_pop,
    output      logic                 o_room,
    output      logic                 o_valid,
    output      pistok_pkg::t_result  o_head
);

    pistok_pkg::t_result               r_mem [pistok_pkg::Q_DEPTH];
    logic [pistok_pkg::Q_PTR_W-1:0]    r_wr_ptr;
    logic [pistok_pkg::Q_PTR_W-1:0]    r_rd_ptr;
    logic [pistok_pkg::Q_CNT_W-1:0]    r_count;
    logic [pistok_pkg::Q_PTR_W-1:0]    n_wr_ptr;
    logic [pistok_pkg::Q_PTR_W-1:0]    n_rd_ptr;
    logic [pistok_pkg::Q_CNT_W-1:0]    n_count;
    logic [pistok_pkg::Q_PTR_W-1:0]    wr_ptr1;
    logic [1:0]                        push_cnt;
    logic                              pop_ok;

    assign push_cnt = i_push_en ? i_push.count : 2'd0;
    assign pop_ok   = i_pop && (r_count != '0);
    assign wr_ptr1  = r_wr_ptr + pistok_pkg::Q_PTR_W'(1);

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr + pistok_pkg::Q_PTR_W'(push_cnt);
        n_rd_ptr = r_rd_ptr + pistok_pkg::Q_PTR_W'(pop_ok);
        n_count  = r_count + pistok_pkg::Q_CNT_W'(push_cnt) - pistok_pkg::Q_CNT_W'(pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (push_cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.res0;
        end
        if (push_cnt == 2'd2) begin
            r_mem[wr_ptr1] <= i_push.res1;
        end
    end

    // head of queue and room for a full byte's worth of results
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign o_room  = (r_count <= pistok_pkg::Q_ROOM_LIMIT);

    // checks
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= pistok_pkg::Q_CNT_W'(pistok_pkg::Q_DEPTH))
        else $error("result queue overfilled");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push_en && i_push.count != 2'd0) |-> o_room)
        else $error("results pushed without room");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && ((r_wr_ptr - r_rd_ptr) != pistok_pkg::Q_PTR_W'(r_count)))
        |-> (r_count == pistok_pkg::Q_CNT_W'(pistok_pkg::Q_DEPTH)))
        else $error("fill count disagrees with pointers");

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// self-checking bench for punctuation_id_string_tokenizer: a queue-fed byte driver,
// a lexer predictor that forms the expected token results, and a result monitor
// depends on pistok_pkg and the tokenizer rtl
`timescale 1ns / 1ps

module tb;

    localparam int QUIET_LIMIT  = 2000;
    localparam int CALM_TAIL    = 100;
    localparam int SETTLE_TICKS = 8;
    localparam int RANDOM_BYTES = 900;

    // one source byte waiting to be sent; drain_first holds it until all results are in
    typedef struct packed {
        logic       drain_first;
        logic [7:0] ch;
    } t_src_byte;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       src_valid = 1'b0;
    logic [7:0] src_byte = 8'h00;
    logic       sink_stall = 1'b0;

    logic       o_stall;
    logic       o_valid;
    logic [3:0] o_kind;
    logic [7:0] o_char_out;
    logic       o_has_char;
    logic       o_token_start;
    logic       o_token_end;
    logic       o_last_of_run;

    t_src_byte           source_bytes[$];
    pistok_pkg::t_result pending_tokens[$];
    logic [1:0]          lex_mode = pistok_pkg::MODE_IDLE;
    int                  mismatch_count = 0;
    int                  bytes_sent = 0;
    int                  results_seen = 0;
    int                  send_gap_left = 0;
    int                  stall_left = 0;
    int                  send_idle_pct = 0;
    int                  stall_pct = 0;
    int                  quiet_cycles = 0;

    punctuation_id_string_tokenizer dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_valid       (src_valid),
        .o_stall       (o_stall),
        .i_byte_in     (src_byte),
        .o_valid       (o_valid),
        .i_stall       (sink_stall),
        .o_kind        (o_kind),
        .o_char_out    (o_char_out),
        .o_has_char    (o_has_char),
        .o_token_start (o_token_start),
        .o_token_end   (o_token_end),
        .o_last_of_run (o_last_of_run)
    );

    // 4 ns clock
    always begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic logic is_word_char(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic pistok_pkg::t_result token_res(input logic [3:0] kind,
                                                      input logic [7:0] ch,
                                                      input logic has, input logic st,
                                                      input logic en);
        pistok_pkg::t_result r;
        r.kind        = kind;
        r.char_out    = has ? ch : 8'h00;
        r.has_char    = has;
        r.token_start = st;
        r.token_end   = en;
        r.last_of_run = 1'b0;
        return r;
    endfunction

    // expected results of one accepted byte, appended to pending_tokens
    function automatic void lex_byte(input logic [7:0] c);
        pistok_pkg::t_result res[2];
        int                  n;
        logic                as_idle;
        logic [3:0]          k;
        n = 0;
        as_idle = 1'b1;
        case (lex_mode)
            pistok_pkg::MODE_STR: begin
                if (c == pistok_pkg::CH_QUOTE) begin
                    res[n] = token_res(pistok_pkg::KIND_STRING, 8'h00, 1'b0, 1'b0, 1'b1);
                    n++;
                    lex_mode = pistok_pkg::MODE_IDLE;
                    as_idle = 1'b0;
                end else if (c == pistok_pkg::CH_NUL) begin
                    // zero closes an unterminated string, eof follows
                    res[n] = token_res(pistok_pkg::KIND_STRING, 8'h00, 1'b0, 1'b0, 1'b1);
                    n++;
                    lex_mode = pistok_pkg::MODE_IDLE;
                end else begin
                    res[n] = token_res(pistok_pkg::KIND_STRING, c, 1'b1, 1'b0, 1'b0);
                    n++;
                    as_idle = 1'b0;
                end
            end
            pistok_pkg::MODE_ID: begin
                if (is_word_char(c)) begin
                    res[n] = token_res(pistok_pkg::KIND_ID, c, 1'b1, 1'b0, 1'b0);
                    n++;
                    as_idle = 1'b0;
                end else begin
                    res[n] = token_res(pistok_pkg::KIND_ID, 8'h00, 1'b0, 1'b0, 1'b1);
                    n++;
                    lex_mode = pistok_pkg::MODE_IDLE;
                end
            end
            default: begin
                lex_mode = pistok_pkg::MODE_IDLE;
            end
        endcase
        // idle handling, also for the byte that ended an identifier or string
        if (as_idle) begin
            if (c == pistok_pkg::CH_NUL) begin
                res[n] = token_res(pistok_pkg::KIND_EOF, 8'h00, 1'b0, 1'b1, 1'b1);
                n++;
            end else if (c == pistok_pkg::CH_QUOTE) begin
                res[n] = token_res(pistok_pkg::KIND_STRING, 8'h00, 1'b0, 1'b1, 1'b0);
                n++;
                lex_mode = pistok_pkg::MODE_STR;
            end else if (is_word_char(c)) begin
                res[n] = token_res(pistok_pkg::KIND_ID, c, 1'b1, 1'b1, 1'b0);
                n++;
                lex_mode = pistok_pkg::MODE_ID;
            end else if (c != pistok_pkg::CH_SPACE && c != pistok_pkg::CH_NEWLINE) begin
                case (c)
                    pistok_pkg::CH_EQUALS: k = pistok_pkg::KIND_EQUALS;
                    pistok_pkg::CH_LPAREN: k = pistok_pkg::KIND_LPAREN;
                    pistok_pkg::CH_RPAREN: k = pistok_pkg::KIND_RPAREN;
                    pistok_pkg::CH_SEMI:   k = pistok_pkg::KIND_SEMI;
                    pistok_pkg::CH_COMMA:  k = pistok_pkg::KIND_COMMA;
                    default:               k = pistok_pkg::KIND_UNKNOWN;
                endcase
                res[n] = token_res(k, c, 1'b1, 1'b1, 1'b1);
                n++;
            end
        end
        if (n > 0) begin
            res[n - 1].last_of_run = 1'b1;
        end
        for (int i = 0; i < n; i++) begin
            pending_tokens.push_back(res[i]);
        end
    endfunction

    function automatic int pick_idle_pct();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 12;
            default: return 40;
        endcase
    endfunction

    function automatic logic [7:0] rand_word_char();
        int r;
        r = $urandom_range(0, 61);
        if (r < 10) begin
            return 8'(8'h30 + r);
        end else if (r < 36) begin
            return 8'(8'h41 + r - 10);
        end
        return 8'(8'h61 + r - 36);
    endfunction

    function automatic logic [7:0] rand_string_char();
        logic [7:0] c;
        c = 8'($urandom_range(1, 255));
        while (c == pistok_pkg::CH_QUOTE) begin
            c = 8'($urandom_range(1, 255));
        end
        return c;
    endfunction

    function automatic void queue_byte(input logic [7:0] c, input logic drain);
        t_src_byte b;
        b.ch = c;
        b.drain_first = drain;
        source_bytes.push_back(b);
    endfunction

    task automatic check_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            mismatch_count++;
            $display("%0t ns: %s mismatch, expected %02h actual %02h", $time, field, want, got);
        end
    endtask

    // request driver: sends the oldest queued byte, holds it while stalled
    always @(posedge clk) begin : drive_bytes
        logic       next_valid;
        logic [7:0] next_byte;
        if (!rst_n) begin
            src_valid <= 1'b0;
            src_byte  <= 8'h00;
        end else begin
            next_valid = src_valid;
            next_byte  = src_byte;
            if (src_valid && !o_stall) begin
                lex_byte(src_byte);
                void'(source_bytes.pop_front());
                bytes_sent++;
                if (bytes_sent % 64 == 0) begin
                    send_idle_pct = pick_idle_pct();
                end
            end
            if (!(src_valid && o_stall)) begin
                next_valid = 1'b0;
                if (send_gap_left > 0) begin
                    send_gap_left--;
                end else if (source_bytes.size() != 0 &&
                             !(source_bytes[0].drain_first && pending_tokens.size() != 0)) begin
                    if (source_bytes.size() > CALM_TAIL &&
                        $urandom_range(0, 99) < send_idle_pct) begin
                        send_gap_left = $urandom_range(0, 10);
                    end else begin
                        next_valid = 1'b1;
                        next_byte  = source_bytes[0].ch;
                    end
                end
            end
            src_valid <= next_valid;
            src_byte  <= next_byte;
        end
    end

    // result monitor and receiver stall bursts
    always @(posedge clk) begin : watch_results
        pistok_pkg::t_result want;
        if (!rst_n) begin
            sink_stall <= 1'b0;
        end else begin
            if (o_valid && !sink_stall) begin
                if (pending_tokens.size() == 0) begin
                    mismatch_count++;
                    $display("%0t ns: unexpected result, expected none actual kind %0d char %02h",
                             $time, o_kind, o_char_out);
                end else begin
                    want = pending_tokens.pop_front();
                    check_field("kind", 8'(want.kind), 8'(o_kind));
                    check_field("char_out", want.char_out, o_char_out);
                    check_field("has_char", 8'(want.has_char), 8'(o_has_char));
                    check_field("token_start", 8'(want.token_start), 8'(o_token_start));
                    check_field("token_end", 8'(want.token_end), 8'(o_token_end));
                    check_field("last_of_run", 8'(want.last_of_run), 8'(o_last_of_run));
                end
                results_seen++;
                if (results_seen % 64 == 0) begin
                    stall_pct = pick_idle_pct();
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                sink_stall <= 1'b1;
            end else if (source_bytes.size() > CALM_TAIL && $urandom_range(0, 99) < stall_pct) begin
                stall_left = $urandom_range(0, 10);
                sink_stall <= 1'b1;
            end else begin
                sink_stall <= 1'b0;
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge clk) begin
        if (!rst_n) begin
            quiet_cycles <= 0;
        end else if ((src_valid && !o_stall) || (o_valid && !sink_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // stimulus, reset and end of run
    initial begin : stimulus
        logic [7:0] opening[25];
        logic [7:0] punct[5];
        int         n_fed;
        int         len;
        int         pick;
        int         next_drain;
        opening = '{"A", "z", "0", "9", pistok_pkg::CH_EQUALS,
                    pistok_pkg::CH_LPAREN, pistok_pkg::CH_RPAREN, pistok_pkg::CH_SEMI,
                    pistok_pkg::CH_COMMA,
                    pistok_pkg::CH_SPACE, pistok_pkg::CH_NEWLINE, pistok_pkg::CH_NUL,
                    pistok_pkg::CH_QUOTE, pistok_pkg::CH_QUOTE,
                    pistok_pkg::CH_QUOTE, 8'hFF, 8'h80, pistok_pkg::CH_NUL,
                    8'h7F, 8'hFF,
                    "q", pistok_pkg::CH_QUOTE, pistok_pkg::CH_QUOTE,
                    "p", pistok_pkg::CH_NUL};
        punct = '{pistok_pkg::CH_EQUALS, pistok_pkg::CH_LPAREN, pistok_pkg::CH_RPAREN,
                  pistok_pkg::CH_SEMI, pistok_pkg::CH_COMMA};
        send_idle_pct = pick_idle_pct();
        stall_pct = pick_idle_pct();

        // directed opening: identifier, punctuation, whitespace before end, empty string,
        // unterminated string closed by zero (sent only after a full drain), high bytes
        for (int i = 0; i < 25; i++) begin
            queue_byte(opening[i], i == 17);
        end

        // random sources: mostly well-formed tokens, some noise and early ends
        n_fed = 0;
        next_drain = 200;
        while (n_fed < RANDOM_BYTES) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                len = $urandom_range(1, 8);
                repeat (len) queue_byte(rand_word_char(), 1'b0);
                n_fed += len;
            end else if (pick < 50) begin
                queue_byte(pistok_pkg::CH_QUOTE, 1'b0);
                len = $urandom_range(0, 6);
                repeat (len) queue_byte(rand_string_char(), 1'b0);
                n_fed += len + 1;
                if ($urandom_range(0, 9) != 0) begin
                    queue_byte(pistok_pkg::CH_QUOTE, 1'b0);
                    n_fed++;
                end
            end else if (pick < 75) begin
                queue_byte(punct[$urandom_range(0, 4)], 1'b0);
                n_fed++;
            end else if (pick < 85) begin
                queue_byte($urandom_range(0, 1) ? pistok_pkg::CH_SPACE : pistok_pkg::CH_NEWLINE,
                           1'b0);
                n_fed++;
            end else if (pick < 90) begin
                queue_byte(pistok_pkg::CH_NUL, 1'b0);
                n_fed++;
            end else begin
                queue_byte(8'($urandom_range(0, 255)), 1'b0);
                n_fed++;
            end
            if ($urandom_range(0, 2) == 0) begin
                queue_byte($urandom_range(0, 3) == 0 ? pistok_pkg::CH_NEWLINE :
                           pistok_pkg::CH_SPACE, 1'b0);
                n_fed++;
            end
            if (n_fed >= next_drain) begin
                queue_byte(pistok_pkg::CH_SPACE, 1'b1);
                n_fed++;
                next_drain += 200;
            end
        end
        queue_byte(pistok_pkg::CH_NUL, 1'b0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (source_bytes.size() != 0) @(posedge clk);
        while (pending_tokens.size() != 0) @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
